[rtl/core/csb_pkg.sv]
// Shared constants, word types and code helpers for the challenge ball sampler.
`default_nettype none

package csb_pkg;

    localparam int N_COEFFS   = 256;
    localparam int MODULUS    = 8380417;
    localparam int TAU_MAX    = 64;
    localparam int TAU_RESET  = 39;
    localparam int SIGN_BYTES = 8;
    localparam int VAL_W      = 23;
    localparam int IDX_W      = $clog2(N_COEFFS);
    localparam int POS_W      = IDX_W + 1;
    localparam int TAU_W      = 7;
    localparam int SEEN_W     = 4;
    localparam int LANE_W     = $clog2(SIGN_BYTES);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [POS_W-1:0]  N_POS     = POS_W'(N_COEFFS);
    localparam logic [TAU_W-1:0]  TAU_LIMIT = TAU_W'(TAU_MAX);
    localparam logic [TAU_W-1:0]  TAU_INIT  = TAU_W'(TAU_RESET);
    localparam logic [SEEN_W-1:0] SIGN_DONE = SEEN_W'(SIGN_BYTES);

    // register index decoded from paddr[2]
    localparam logic REG_NONZERO_COUNT = 1'b0;

    typedef logic [1:0] code_t;

    localparam code_t CODE_ZERO  = 2'd0;
    localparam code_t CODE_PLUS  = 2'd1;
    localparam code_t CODE_MINUS = 2'd2;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       first;
    } in_word_t;

    typedef struct packed {
        logic [7:0]       moved_index;
        logic [VAL_W-1:0] moved_value;
        logic [7:0]       chosen_index;
        logic [VAL_W-1:0] chosen_value;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic             clear;
        logic [IDX_W-1:0] byte_val;
        logic [POS_W-1:0] pos;
        logic             sign;
        logic             last;
    } cmd_t;

    function automatic logic [VAL_W-1:0] code_value(input code_t code);
        logic [VAL_W-1:0] val;
        case (code)
            CODE_PLUS:  val = VAL_W'(1);
            CODE_MINUS: val = VAL_W'(MODULUS - 1);
            default:    val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[rtl/core/challenge_ball_sampler_core.sv]
// Top level of the challenge ball sampler: configuration register and block wiring.
`default_nettype none

// Takes one hash byte per cycle on the byte channel while byte_stall is low
// and, for each accepted placement byte, returns one word carrying both store
// writes of the swap. A word passes through the command queue, the registered
// store read and the output register, and the swap is written as the word
// enters the output register. The store is two 256 x 2-bit memories with a
// 256-bit written mask, so the first byte of a challenge clears it by zeroing
// the mask, with no sweep. nonzero_count is sampled when a first byte is
// taken; write it only while the block is idle.
module challenge_ball_sampler_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         byte_valid,
    output logic                              byte_stall,
    input  wire csb_pkg::in_word_t            byte_data,
    output logic                              place_valid,
    input  wire logic                         place_stall,
    output csb_pkg::out_word_t                place_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [csb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [csb_pkg::PDATA_W-1:0]  pwdata,
    output logic [csb_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import csb_pkg::*;

    logic [TAU_W-1:0] tau_reg;
    logic             push_valid;
    cmd_t             push_cmd;
    logic             push_full;
    logic             pop_valid;
    cmd_t             pop_cmd;
    logic             pop_stall;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NONZERO_COUNT)
                  ? {{(PDATA_W-TAU_W){1'b0}}, tau_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg <= TAU_INIT;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_NONZERO_COUNT))
        begin
            tau_reg <= pwdata[TAU_W-1:0];
        end
    end

    csb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .tau        (tau_reg),
        .push_full  (push_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    csb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_full  (push_full),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_stall  (pop_stall)
    );

    csb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (pop_valid),
        .cmd         (pop_cmd),
        .cmd_stall   (pop_stall),
        .place_valid (place_valid),
        .place_stall (place_stall),
        .place_data  (place_data)
    );

endmodule

`default_nettype wire

[rtl/core/csb_front.sv]
// Front end: sign word collection, position tracking, rejection and command issue.
`default_nettype none

module csb_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire csb_pkg::in_word_t byte_data,
    input  wire logic [6:0]        tau,
    input  wire logic              push_full,
    output logic                   push_valid,
    output csb_pkg::cmd_t          push_cmd
);
    import csb_pkg::*;

    logic [63:0]       sign_word_reg, sign_word_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic              busy_reg, busy_next;
    logic              accept;
    logic [TAU_W-1:0]  tau_sat;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  pos_inc;
    logic              place_last;

    assign byte_stall = push_full;
    assign accept     = byte_valid && !push_full;
    assign tau_sat    = (tau > TAU_LIMIT) ? TAU_LIMIT : tau;
    assign start_pos  = N_POS - {{(POS_W-TAU_W){1'b0}}, tau_sat};
    assign pos_inc    = position_reg + POS_W'(1);
    assign place_last = (pos_inc >= N_POS);

    always_comb
    begin
        sign_word_next = sign_word_reg;
        seen_next      = seen_reg;
        position_next  = position_reg;
        busy_next      = busy_reg;
        push_valid     = 1'b0;
        push_cmd       = '0;
        if (accept)
        begin
            if (byte_data.first)
            begin
                sign_word_next  = {56'd0, byte_data.stream_byte};
                seen_next       = SEEN_W'(1);
                position_next   = start_pos;
                busy_next       = (tau_sat != '0);
                push_valid      = 1'b1;
                push_cmd.clear  = 1'b1;
                push_cmd.pos    = start_pos;
            end
            else if (busy_reg)
            begin
                if (seen_reg < SIGN_DONE)
                begin
                    sign_word_next[8*seen_reg[LANE_W-1:0] +: 8] = byte_data.stream_byte;
                    seen_next = seen_reg + SEEN_W'(1);
                end
                else if ({1'b0, byte_data.stream_byte} <= position_reg)
                begin
                    push_valid        = 1'b1;
                    push_cmd.byte_val = byte_data.stream_byte;
                    push_cmd.pos      = position_reg;
                    push_cmd.sign     = sign_word_reg[0];
                    push_cmd.last     = place_last;
                    sign_word_next    = {1'b0, sign_word_reg[63:1]};
                    position_next     = pos_inc;
                    if (place_last)
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_word_reg <= '0;
            seen_reg      <= '0;
            position_reg  <= '0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            sign_word_reg <= sign_word_next;
            seen_reg      <= seen_next;
            position_reg  <= position_next;
            busy_reg      <= busy_next;
        end
    end

    a_place_needs_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_cmd.clear) |-> (busy_reg && seen_reg == SIGN_DONE))
        else $error("placement issued before sign word complete");

    a_busy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (position_reg < N_POS))
        else $error("busy with position past the last coefficient");

endmodule

`default_nettype wire

[rtl/core/csb_queue.sv]
// Short command queue between the front end and the store back end.
`default_nettype none

module csb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    input  wire csb_pkg::cmd_t push_cmd,
    output logic               push_full,
    output logic               pop_valid,
    output csb_pkg::cmd_t      pop_cmd,
    input  wire logic          pop_stall
);
    import csb_pkg::*;

    cmd_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_full = (count_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entries_reg[rd_ptr_reg];
    assign do_push   = push_valid && !push_full;
    assign do_pop    = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("command queue overflow");

endmodule

`default_nettype wire

[rtl/core/csb_back.sv]
// Back end: coefficient store swap, read forwarding and result output register.
`default_nettype none

module csb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire csb_pkg::cmd_t     cmd,
    output logic                   cmd_stall,
    output logic                   place_valid,
    input  wire logic              place_stall,
    output csb_pkg::out_word_t     place_data
);
    import csb_pkg::*;

    code_t              sign_mem  [N_COEFFS];
    code_t              moved_mem [N_COEFFS];
    logic [N_COEFFS-1:0] avalid_reg;

    logic              st_valid_reg, st_valid_next;
    cmd_t              st_cmd_reg;
    logic              st_avalid_reg;
    logic              st_hita_reg;
    code_t             st_fwda_reg;
    logic              st_hitb_reg;
    code_t             st_fwdb_reg;
    code_t             sign_rdata_reg;
    code_t             moved_rdata_reg;
    logic [POS_W-1:0]  start_reg;

    logic              out_valid_reg;
    out_word_t         out_data_reg;

    logic              out_free;
    logic              st_move;
    logic              load;
    logic              place_write;
    logic              clear_move;
    logic              in_moved;
    code_t             old_code;
    code_t             sign_code;
    logic [IDX_W-1:0]  st_pos_idx;

    assign out_free    = !out_valid_reg || !place_stall;
    assign st_move     = st_valid_reg && (st_cmd_reg.clear || out_free);
    assign cmd_stall   = st_valid_reg && !st_move;
    assign load        = cmd_valid && !cmd_stall;
    assign place_write = st_move && !st_cmd_reg.clear;
    assign clear_move  = st_move && st_cmd_reg.clear;
    assign st_pos_idx  = st_cmd_reg.pos[IDX_W-1:0];
    assign sign_code   = st_cmd_reg.sign ? CODE_MINUS : CODE_PLUS;
    assign in_moved    = ({1'b0, st_cmd_reg.byte_val} >= start_reg)
                      && ({1'b0, st_cmd_reg.byte_val} < st_cmd_reg.pos);

    always_comb
    begin
        if (st_hita_reg)
        begin
            old_code = st_fwda_reg;
        end
        else if (st_avalid_reg)
        begin
            old_code = sign_rdata_reg;
        end
        else if (in_moved)
        begin
            old_code = st_hitb_reg ? st_fwdb_reg : moved_rdata_reg;
        end
        else
        begin
            old_code = CODE_ZERO;
        end
    end

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (load)
        begin
            st_valid_next = 1'b1;
        end
        else if (st_move)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            avalid_reg    <= '0;
            start_reg     <= '0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
            if (place_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!place_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear_move)
            begin
                avalid_reg <= '0;
                start_reg  <= st_cmd_reg.pos;
            end
            else if (place_write)
            begin
                avalid_reg[st_cmd_reg.byte_val] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (place_write)
        begin
            sign_mem[st_cmd_reg.byte_val] <= sign_code;
            moved_mem[st_pos_idx]         <= old_code;
            out_data_reg.moved_index      <= st_pos_idx;
            out_data_reg.moved_value      <= code_value(old_code);
            out_data_reg.chosen_index     <= st_cmd_reg.byte_val;
            out_data_reg.chosen_value     <= code_value(sign_code);
            out_data_reg.last             <= st_cmd_reg.last;
        end
        if (load)
        begin
            sign_rdata_reg  <= sign_mem[cmd.byte_val];
            moved_rdata_reg <= moved_mem[cmd.byte_val];
            st_cmd_reg      <= cmd;
            st_avalid_reg   <= avalid_reg[cmd.byte_val] && !clear_move;
            st_hita_reg     <= place_write && (cmd.byte_val == st_cmd_reg.byte_val);
            st_fwda_reg     <= sign_code;
            st_hitb_reg     <= place_write && (cmd.byte_val == st_pos_idx);
            st_fwdb_reg     <= old_code;
        end
    end

    assign place_valid = out_valid_reg;
    assign place_data  = out_data_reg;

    a_chosen_not_past_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg && !st_cmd_reg.clear) |-> ({1'b0, st_cmd_reg.byte_val} <= st_cmd_reg.pos))
        else $error("chosen index beyond current position");

    a_write_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        place_write |=> out_valid_reg)
        else $error("store swap without a result word");

endmodule

`default_nettype wire

[tb/challenge_ball_sampler_core_tb.sv]
// Self-checking testbench for challenge_ball_sampler_core with a built-in challenge predictor.
`timescale 1ns / 100ps

module challenge_ball_sampler_core_tb;

    import csb_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int                 SETTLE_CYCLES = 8;
    localparam int                 TARGET_BYTES  = 1850;
    localparam logic [PADDR_W-1:0] TAU_ADDR      = {REG_NONZERO_COUNT, 2'b00};

    logic                clk;
    logic                rst_n;
    logic                byte_valid;
    logic                byte_stall;
    in_word_t            byte_data;
    logic                place_valid;
    logic                place_stall;
    out_word_t           place_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // predicted block state
    logic [TAU_W-1:0]    tau_cfg;
    logic [63:0]         sign_bits;
    logic [SEEN_W-1:0]   signs_seen;
    logic [POS_W-1:0]    cur_pos;
    code_t               coef [N_COEFFS];
    logic                active;
    logic [7:0]          last_chosen;

    out_word_t           pending_places[$];
    out_word_t           want;
    int                  errors;
    int                  bytes_sent;
    int                  sender_idle_pct;
    int                  stall_pct;
    int                  hold_left;

    challenge_ball_sampler_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_data   (byte_data),
        .place_valid (place_valid),
        .place_stall (place_stall),
        .place_data  (place_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("challenge_ball_sampler_core test failed");
        $finish;
    end

    function automatic logic [VAL_W-1:0] coef_value(input code_t c);
        if (c == CODE_PLUS)
            return VAL_W'(1);
        if (c == CODE_MINUS)
            return VAL_W'(MODULUS - 1);
        return '0;
    endfunction

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned got_v);
        if (exp_v != got_v)
            flag_error($sformatf("mismatch on %s: expected %0d, got %0d", name, exp_v, got_v));
    endfunction

    function automatic void clear_ball();
        tau_cfg     = TAU_INIT;
        sign_bits   = '0;
        signs_seen  = '0;
        cur_pos     = '0;
        active      = 1'b0;
        last_chosen = '0;
        foreach (coef[i])
            coef[i] = CODE_ZERO;
    endfunction

    // advance the predicted sampler by one accepted byte
    function automatic void ball_step(input logic [7:0] b, input logic f);
        logic [TAU_W-1:0] tau;
        code_t            old_c;
        code_t            new_c;
        out_word_t        w;
        if (f)
        begin
            tau = (tau_cfg > TAU_LIMIT) ? TAU_LIMIT : tau_cfg;
            foreach (coef[i])
                coef[i] = CODE_ZERO;
            sign_bits  = {56'b0, b};
            signs_seen = SEEN_W'(1);
            cur_pos    = N_POS - POS_W'(tau);
            active     = (tau != 0);
        end
        else if (active)
        begin
            if (signs_seen < SIGN_DONE)
            begin
                sign_bits  = sign_bits | (64'(b) << (8 * signs_seen));
                signs_seen = signs_seen + 1'b1;
            end
            else if (POS_W'(b) <= cur_pos)
            begin
                old_c = coef[b];
                new_c = sign_bits[0] ? CODE_MINUS : CODE_PLUS;
                coef[cur_pos[7:0]] = old_c;
                coef[b]            = new_c;
                sign_bits          = sign_bits >> 1;
                w.moved_index  = cur_pos[7:0];
                w.moved_value  = coef_value(old_c);
                w.chosen_index = b;
                w.chosen_value = coef_value(new_c);
                cur_pos        = cur_pos + 1'b1;
                w.last         = (cur_pos >= N_POS);
                if (w.last)
                    active = 1'b0;
                last_chosen = b;
                pending_places.push_back(w);
            end
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return cur_pos[7:0];
        if (r < 22)
            return last_chosen;
        if (r < 32)
            return 8'($urandom_range(cur_pos > 255 ? 255 : cur_pos));
        return 8'($urandom_range(255));
    endfunction

    function automatic void set_idle(input idle_mode_t m);
        case (m)
            IDLE_SENDER:   begin sender_idle_pct = 57; stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 57; end
            IDLE_BOTH:     begin sender_idle_pct = 22; stall_pct = 22; end
            default:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endfunction

    // receiver: random stalls, overridden by a counted hold-off
    initial
    begin
        place_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                place_stall <= 1'b1;
                hold_left--;
            end
            else
                place_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && place_valid && !place_stall)
        begin
            if (pending_places.size() == 0)
                flag_error($sformatf("unexpected word %h", place_data));
            else
            begin
                want = pending_places.pop_front();
                check_field("moved_index", want.moved_index, place_data.moved_index);
                check_field("moved_value", want.moved_value, place_data.moved_value);
                check_field("chosen_index", want.chosen_index, place_data.chosen_index);
                check_field("chosen_value", want.chosen_value, place_data.chosen_value);
                check_field("last", want.last, place_data.last);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f);
        in_word_t w;
        w.stream_byte = b;
        w.first       = f;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= w;
        do @(posedge clk); while (byte_stall);
        ball_step(b, f);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_places.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tau(input logic [TAU_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TAU_ADDR;
        pwdata  <= PDATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tau_cfg = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        check_field("nonzero_count readback", PDATA_W'(v), prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_challenge(input int cut);
        int n;
        n = 0;
        send_byte(8'($urandom_range(255)), 1'b1);
        while (active && (cut == 0 || n < cut))
        begin
            if (signs_seen < SIGN_DONE)
                send_byte(8'($urandom_range(255)), 1'b0);
            else
                send_byte(pick_byte(), 1'b0);
            n++;
        end
        repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_directed();
        set_idle(IDLE_NONE);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(cur_pos[7:0], 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(cur_pos[7:0] - 8'd1, 1'b0);
        send_byte(8'(N_COEFFS - TAU_RESET), 1'b0);
        // restart in the middle of a challenge
        send_byte(8'h00, 1'b1);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(cur_pos[7:0], 1'b0);
        send_byte(8'h00, 1'b0);
        wait_idle();
    endtask

    task automatic test_tau_extremes();
        set_idle(IDLE_BOTH);
        write_tau(7'd0);
        send_byte(8'h3C, 1'b1);
        repeat (10) send_byte(8'($urandom_range(255)), 1'b0);
        wait_idle();
        write_tau(7'd1);
        send_challenge(0);
        send_challenge(0);
        wait_idle();
        write_tau(7'd64);
        send_challenge(0);
        wait_idle();
        write_tau(7'd127);
        send_challenge(0);
        wait_idle();
        write_tau(7'd65);
        send_challenge(0);
        wait_idle();
    endtask

    task automatic test_holdoff();
        set_idle(IDLE_NONE);
        write_tau(7'd64);
        hold_left = 300;
        send_challenge(0);
        wait_idle();
        set_idle(IDLE_SENDER);
        hold_left = 120;
        send_challenge(0);
        send_challenge(0);
        wait_idle();
    endtask

    task automatic test_random();
        int phase;
        int r;
        phase = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            set_idle(idle_mode_t'(phase % 4));
            r = $urandom_range(99);
            if (r < 10)
                write_tau(7'd1);
            else if (r < 20)
                write_tau(7'd64);
            else if (r < 24)
                write_tau(7'd0);
            else if (r < 28)
                write_tau(7'd127);
            else
                write_tau(7'($urandom_range(1, 64)));
            repeat (3)
            begin
                if ($urandom_range(99) < 10)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
                if ($urandom_range(99) < 12)
                    send_challenge($urandom_range(1, 40));
                else
                    send_challenge(0);
            end
            wait_idle();
            phase++;
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        byte_valid      = 1'b0;
        byte_data       = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        errors          = 0;
        bytes_sent      = 0;
        hold_left       = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        clear_ball();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_tau_extremes();
        test_holdoff();
        test_random();

        wait_idle();
        if (errors == 0 && pending_places.size() == 0)
            $display("challenge_ball_sampler_core test passed");
        else
            $display("challenge_ball_sampler_core test failed");
        $finish;
    end

endmodule
